>>> design/mbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package mbp_pkg;

  localparam int unsigned MAX_WRITE_BITS_DEF = 32;
  localparam int unsigned BYTE_W             = 8;
  localparam int unsigned VALUE_W            = 32;
  localparam int unsigned COUNT_W            = 6;
  localparam int unsigned INDEX_W            = 32;
  localparam int unsigned NBITS_W            = 4;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic emit;    // load the next byte into the output register
  } mbp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start;     // the offered item produces at least one byte
    logic last;      // the byte about to be emitted is the final one
    logic out_free;  // output register can take a byte this cycle
  } mbp_status_t;

endpackage

`default_nettype wire

>>> design/mbp_ctrl.sv
// Controller state machine for the MSB-first bit packer.
// Depends on mbp_pkg for the command and status structs.
`default_nettype none

module mbp_ctrl
  import mbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mbp_status_t status_i,
  output mbp_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    cmd_o.accept = in_valid_i && in_ready_o;
    cmd_o.emit   = (state_q == ST_EMIT) && status_i.out_free;
    state_d      = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && status_i.start) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd_o.emit && status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/mbp_datapath.sv
// Datapath of the MSB-first bit packer: bit window, pending byte, byte counter
// and output register. Depends on mbp_pkg; driven by mbp_ctrl.
`default_nettype none

module mbp_datapath
  import mbp_pkg::*;
#(
  parameter int unsigned MAX_WRITE_BITS = MAX_WRITE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mbp_cmd_t             cmd_i,
  output mbp_status_t          status_o,
  input  logic                 func_i,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic [COUNT_W-1:0]   bit_count_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    out_byte_o,
  output logic [INDEX_W-1:0]   byte_index_o,
  output logic [NBITS_W-1:0]   valid_bits_o,
  output logic                 last_of_run_o
);

  localparam int unsigned WW   = MAX_WRITE_BITS + BYTE_W;
  localparam int unsigned SW   = $clog2(WW + 1);
  localparam int unsigned TW   = $clog2(WW);
  localparam int unsigned MAXB = (MAX_WRITE_BITS + BYTE_W - 1) / BYTE_W;
  localparam int unsigned NBW  = $clog2(MAXB + 1);
  localparam int unsigned CMPW = $clog2(MAX_WRITE_BITS + 1) > COUNT_W
                                 ? $clog2(MAX_WRITE_BITS + 1) : COUNT_W;

  logic [BYTE_W-1:0]  pending_q, pending_d;
  logic [2:0]         fill_q, fill_d;
  logic [INDEX_W-1:0] bytes_q, bytes_d;
  logic [WW-1:0]      window_q, window_d;
  logic [NBW-1:0]     nbytes_q, nbytes_d;
  logic [2:0]         rem_q, rem_d;
  logic               flush_q, flush_d;
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  out_byte_q;
  logic [INDEX_W-1:0] out_index_q;
  logic [NBITS_W-1:0] out_nbits_q;
  logic               out_last_q;

  logic               count_ok;
  logic [WW-1:0]      val_ext, val_mask, val_placed;
  logic [SW-1:0]      shamt;
  logic [TW-1:0]      total;
  logic [NBW-1:0]     nbytes_new;
  logic [BYTE_W-1:0]  next_byte;

  always_comb begin
    count_ok = (bit_count_i != '0) &&
               (CMPW'(bit_count_i) <= CMPW'(MAX_WRITE_BITS));
    val_ext  = WW'(value_i);
    for (int i = 0; i < WW; i++) begin
      val_mask[i] = val_ext[i] && (i < int'(bit_count_i));
    end
    // first appended bit lands just below the pending bits
    shamt      = SW'(WW) - SW'(fill_q) - SW'(bit_count_i);
    val_placed = val_mask << shamt;
    total      = TW'(fill_q) + TW'(bit_count_i);
    nbytes_new = NBW'(total >> 3);
    next_byte  = window_q[WW-BYTE_W-1 -: BYTE_W];
  end

  always_comb begin
    status_o.out_free = !out_valid_q || out_ready_i;
    status_o.last     = (nbytes_q == NBW'(1));
    if (func_i == FUNC_FLUSH) begin
      status_o.start = (fill_q != '0);
    end else begin
      status_o.start = count_ok && (nbytes_new != '0);
    end
  end

  always_comb begin
    pending_d   = pending_q;
    fill_d      = fill_q;
    bytes_d     = bytes_q;
    window_d    = window_q;
    nbytes_d    = nbytes_q;
    rem_d       = rem_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.accept) begin
      if (func_i == FUNC_FLUSH) begin
        if (fill_q != '0) begin
          window_d = {pending_q, {(WW-BYTE_W){1'b0}}};
          nbytes_d = NBW'(1);
          rem_d    = '0;
          flush_d  = 1'b1;
        end
      end else if (count_ok) begin
        if (nbytes_new == '0) begin
          // no byte completes: merge straight into the pending byte
          pending_d = pending_q | val_placed[WW-1 -: BYTE_W];
          fill_d    = total[2:0];
        end else begin
          window_d = {pending_q, {(WW-BYTE_W){1'b0}}} | val_placed;
          nbytes_d = nbytes_new;
          rem_d    = total[2:0];
          flush_d  = 1'b0;
        end
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      bytes_d     = bytes_q + INDEX_W'(1);
      window_d    = window_q << BYTE_W;
      nbytes_d    = nbytes_q - NBW'(1);
      if (status_o.last) begin
        pending_d = next_byte;
        fill_d    = rem_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      fill_q      <= '0;
      bytes_q     <= '0;
      nbytes_q    <= '0;
      rem_q       <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      fill_q      <= fill_d;
      bytes_q     <= bytes_d;
      nbytes_q    <= nbytes_d;
      rem_q       <= rem_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
    if (cmd_i.emit) begin
      out_byte_q  <= window_q[WW-1 -: BYTE_W];
      out_index_q <= bytes_q;
      out_nbits_q <= flush_q ? NBITS_W'(fill_q) : NBITS_W'(BYTE_W);
      out_last_q  <= status_o.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_index_o  = out_index_q;
  assign valid_bits_o  = out_nbits_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

>>> design/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: controller plus datapath.
// Depends on mbp_pkg, mbp_ctrl and mbp_datapath.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid_i/in_ready_o | func_i, value_i, bit_count_i
//   out     | output    | out_valid_o/out_ready_i| out_byte_o, byte_index_o, valid_bits_o,
//           |           |                       | last_of_run_o
//
// An item producing N bytes (N = 0..4 at the default width) keeps the input
// closed until its last byte is emitted; one byte leaves the window per cycle while the output is not stalled.
// Items producing no byte are taken one per cycle.
// A stalled output holds the byte and freezes emission; a new item may be
// accepted while the final byte of the previous one still waits.
// Reset clears the pending byte, its fill count and the byte index.
`default_nettype none

module msb_first_bit_packer
  import mbp_pkg::*;
#(
  parameter int unsigned MAX_WRITE_BITS = MAX_WRITE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [COUNT_W-1:0] bit_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic [INDEX_W-1:0] byte_index_o,
  output logic [NBITS_W-1:0] valid_bits_o,
  output logic               last_of_run_o
);

  mbp_cmd_t    cmd;
  mbp_status_t status;

  mbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbp_datapath #(
    .MAX_WRITE_BITS (MAX_WRITE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (func_i),
    .value_i       (value_i),
    .bit_count_i   (bit_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_index_o  (byte_index_o),
    .valid_bits_o  (valid_bits_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

>>> design/mbp_checker.sv
// Port-level checks for the MSB-first bit packer, bound to the top level.
// Depends on mbp_pkg for field widths.
`default_nettype none

module mbp_checker
  import mbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [BYTE_W-1:0]  out_byte_o,
  input  logic [INDEX_W-1:0] byte_index_o,
  input  logic [NBITS_W-1:0] valid_bits_o,
  input  logic               last_of_run_o
);

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(byte_index_o) && $stable(valid_bits_o) && $stable(last_of_run_o))
    else $error("output changed while stalled");

  a_nbits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> valid_bits_o != '0 && valid_bits_o <= NBITS_W'(BYTE_W))
    else $error("valid_bits out of range");

  // a padded byte only ever closes a flush
  a_partial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_bits_o != NBITS_W'(BYTE_W) |-> last_of_run_o)
    else $error("partial byte not marked last");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=>
      !out_valid_o || byte_index_o == $past(byte_index_o) + INDEX_W'(1))
    else $error("byte index not consecutive");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_o    (out_byte_o),
  .byte_index_o  (byte_index_o),
  .valid_bits_o  (valid_bits_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire

>>> tb/msb_first_bit_packer_test.sv
// Self-checking testbench for msb_first_bit_packer: directed and random transactions with
// random idling on both channels, checked against an in-bench bit packing predictor.
// Depends on mbp_pkg and the msb_first_bit_packer RTL.
module msb_first_bit_packer_test;
  import mbp_pkg::*;

  localparam int unsigned ITEM_TARGET = 400;
  localparam int unsigned CALM_TAIL   = 60;
  localparam int unsigned HOLD_OFF    = 80;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS = 40;

  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
    logic [NBITS_W-1:0] nbits;
    logic               last;
  } stream_byte_t;

  // Tracks the partial byte and byte index, and holds the bytes still owed by the block.
  class packer_board;
    logic [BYTE_W-1:0]  partial;
    int unsigned        fill;
    logic [INDEX_W-1:0] next_index;
    stream_byte_t       owed_bytes[$];
    int unsigned        errors;
    int unsigned        seen;

    function new();
      partial    = '0;
      fill       = 0;
      next_index = '0;
      errors     = 0;
      seen       = 0;
    endfunction

    function void push_byte(logic [NBITS_W-1:0] nbits, logic last);
      stream_byte_t b;
      b.data  = partial;
      b.index = next_index;
      b.nbits = nbits;
      b.last  = last;
      owed_bytes.push_back(b);
      next_index = next_index + 1'b1;
      partial    = '0;
      fill       = 0;
    endfunction

    function void take_item(logic func, logic [VALUE_W-1:0] value,
                            logic [COUNT_W-1:0] count);
      int unsigned total;
      int unsigned made;
      made = 0;
      if (func == FUNC_FLUSH) begin
        // an empty partial byte flushes to nothing
        if (fill != 0) push_byte(NBITS_W'(fill), 1'b1);
      end else if (count != 0 && count <= MAX_WRITE_BITS_DEF) begin
        total = (fill + count) / BYTE_W;
        for (int i = int'(count) - 1; i >= 0; i--) begin
          partial[BYTE_W - 1 - fill] = value[i];
          fill++;
          if (fill == BYTE_W) begin
            made++;
            push_byte(NBITS_W'(BYTE_W), made == total);
          end
        end
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        if (errors < MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_byte(logic [BYTE_W-1:0] data, logic [INDEX_W-1:0] index,
                             logic [NBITS_W-1:0] nbits, logic last);
      stream_byte_t want;
      seen++;
      if (owed_bytes.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected byte, expected none, actual 0x%0h at index %0d",
                   $time, data, index);
        errors++;
      end else begin
        want = owed_bytes.pop_front();
        check_field("out_byte", 32'(want.data), 32'(data));
        check_field("byte_index", want.index, index);
        check_field("valid_bits", 32'(want.nbits), 32'(nbits));
        check_field("last_of_run", 32'(want.last), 32'(last));
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               func_i;
  logic [VALUE_W-1:0] value_i;
  logic [COUNT_W-1:0] bit_count_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [BYTE_W-1:0]  out_byte_o;
  logic [INDEX_W-1:0] byte_index_o;
  logic [NBITS_W-1:0] valid_bits_o;
  logic               last_of_run_o;

  packer_board board;
  bit          calm = 1'b0;
  int unsigned quiet_cycles = 0;

  msb_first_bit_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .bit_count_i   (bit_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_index_o  (byte_index_o),
    .valid_bits_o  (valid_bits_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor both channels on the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o === 1'b1)
        board.take_item(func_i, value_i, bit_count_i);
      if (out_valid_o === 1'b1 && out_ready_i)
        board.match_byte(out_byte_o, byte_index_o, valid_bits_o, last_of_run_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("msb_first_bit_packer test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Optionally idle the sender, then hold the transaction until it is taken.
  task automatic feed(input logic func, input logic [VALUE_W-1:0] value,
                      input logic [COUNT_W-1:0] count);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= func;
    value_i     <= value;
    bit_count_i <= count;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
  endtask

  // Mostly well-formed appends, with flushes and ignored counts mixed in.
  task automatic feed_random(output bit counted);
    int unsigned        pick;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    pick  = $urandom_range(0, 99);
    value = $urandom;
    if ($urandom_range(0, 15) == 0) value = ($urandom_range(0, 1) != 0) ? '1 : '0;
    counted = 1'b0;
    if (pick < 8) begin
      feed(FUNC_FLUSH, value, COUNT_W'($urandom));
    end else if (pick < 16) begin
      count = (pick < 10) ? '0
            : COUNT_W'($urandom_range(MAX_WRITE_BITS_DEF + 1, (1 << COUNT_W) - 1));
      feed(FUNC_APPEND, value, count);
    end else begin
      if (pick < 45) count = COUNT_W'($urandom_range(1, BYTE_W));
      else if (pick < 60) count = COUNT_W'(MAX_WRITE_BITS_DEF);
      else count = COUNT_W'($urandom_range(1, MAX_WRITE_BITS_DEF));
      feed(FUNC_APPEND, value, count);
      counted = 1'b1;
    end
  endtask

  // Receiver: random stalls, one long hold-off to back up the block, none at the end.
  initial begin
    bit held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && board.seen >= 120) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        held = 1'b1;
      end else if (calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned appends;
    bit          counted;
    board = new();
    appends = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_APPEND;
    value_i     <= '0;
    bit_count_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ignored counts, and a flush with nothing pending
    feed(FUNC_APPEND, '1, '0);
    feed(FUNC_APPEND, '1, COUNT_W'(MAX_WRITE_BITS_DEF + 1));
    feed(FUNC_APPEND, '1, '1);
    feed(FUNC_FLUSH, '0, '0);
    feed(FUNC_APPEND, 32'h1, 6'd1);
    feed(FUNC_FLUSH, '0, '0);
    // full-width writes from a byte boundary
    feed(FUNC_APPEND, '1, 6'd32);
    feed(FUNC_APPEND, '0, 6'd32);
    feed(FUNC_APPEND, 32'hA5, 6'd8);
    // upper value bits must be dropped
    feed(FUNC_APPEND, 32'h5, 6'd3);
    feed(FUNC_APPEND, 32'hFFFF_FF80, 6'd7);
    // flush operands are ignored
    feed(FUNC_FLUSH, '1, '1);
    feed(FUNC_APPEND, 32'h7F, 6'd7);
    feed(FUNC_APPEND, 32'h8000_0001, 6'd32);
    feed(FUNC_FLUSH, '0, '0);
    feed(FUNC_APPEND, 32'h1234_5678, 6'd31);
    feed(FUNC_APPEND, '1, 6'd24);
    feed(FUNC_APPEND, 32'hDEAD_BEEF, 6'd16);
    feed(FUNC_APPEND, 32'h3, 6'd2);
    feed(FUNC_APPEND, '1, 6'd1);
    feed(FUNC_FLUSH, '0, '0);
    feed(FUNC_FLUSH, '1, '0);

    while (appends < ITEM_TARGET) begin
      if (appends >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
      feed_random(counted);
      appends += counted;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.owed_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (board.errors == 0 && board.owed_bytes.size() == 0) begin
      $display("msb_first_bit_packer test passed");
    end else begin
      $display("msb_first_bit_packer test failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/mbp_pkg.sv
design/mbp_ctrl.sv
design/mbp_datapath.sv
design/msb_first_bit_packer.sv
design/mbp_checker.sv
tb/msb_first_bit_packer_test.sv
